>>> hdl/ptom_pkg.sv
// Package for the price-time order matcher: shared types and codes.
// Used by the interface file and every module of the block.
package ptom_pkg;

    localparam int unsigned PriceW = 32;
    localparam int unsigned QtyW   = 32;
    localparam int unsigned IdW    = 32;

    typedef enum logic [1:0] {
        K_ADD       = 2'd0,
        K_MATCH     = 2'd1,
        K_PEEK_BUY  = 2'd2,
        K_PEEK_SELL = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [PriceW-1:0] price;
        logic [QtyW-1:0]   qty;
        logic [IdW-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_buy;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] order_id;
        logic [3:0]  rank;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] row_price;
        logic [31:0] row_quantity;
        logic [31:0] row_id;
        logic [31:0] trade_total;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_MCHK,
        S_MPOP,
        S_PEEK,
        S_DONE
    } t_state;

    // True when a ranks strictly ahead of b on the given side
    function automatic logic ranks_ahead(input t_entry a, input t_entry b,
                                         input logic buy_side);
        logic r;
        if (a.price != b.price) begin
            r = buy_side ? (a.price > b.price) : (a.price < b.price);
        end else begin
            r = a.id < b.id;
        end
        return r;
    endfunction

endpackage

>>> hdl/ptom_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on ptom_pkg.
interface ptom_req_if import ptom_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ptom_rsp_if import ptom_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/ptom_book.sv
// One book held as a shift line of entries, kept sorted by the insert positions the controller gives.
// Depends on ptom_pkg.
module ptom_book import ptom_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CW    = 5,
    parameter int unsigned IW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_rd_idx,
    output t_entry        o_rd_data,
    input  logic          i_ins,
    input  logic [IW-1:0] i_ins_pos,
    input  t_entry        i_ins_data,
    input  logic          i_pop,
    input  logic          i_wr_head,
    input  logic [QtyW-1:0] i_head_qty,
    output logic [CW-1:0] o_count
);
    t_entry r_ent [DEPTH];
    logic [CW-1:0] r_count;

    assign o_rd_data = r_ent[i_rd_idx];
    assign o_count   = r_count;

    // Shift entries for insert or pop, or update head quantity
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_ins) begin
                if (i == int'(i_ins_pos)) r_ent[i] <= i_ins_data;
                else if (i > int'(i_ins_pos)) r_ent[i] <= r_ent[i-1];
            end else if (i_pop) begin
                if (i < DEPTH - 1) r_ent[i] <= r_ent[i+1];
            end else if (i_wr_head && i == 0) begin
                r_ent[0].qty <= i_head_qty;
            end
        end
    end

    // Track fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_pop) begin
            r_count <= r_count - CW'(1);
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("book count over depth");
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ins |-> r_count < CW'(DEPTH)) else $error("insert into full book");
    a_no_udf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop of empty book");
`endif
endmodule

>>> hdl/ptom_ctrl.sv
// Sequencer: scans a book for insert position, runs match rounds, serves peeks.
// Depends on ptom_pkg; drives two ptom_book instances through the top level.
module ptom_ctrl import ptom_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CW    = 5,
    parameter int unsigned IW    = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptom_req_if.sink        i_req,
    ptom_rsp_if.source      o_rsp,
    output logic [IW-1:0]   o_buy_idx,
    output logic [IW-1:0]   o_sell_idx,
    input  t_entry          i_buy_rd,
    input  t_entry          i_sell_rd,
    input  logic [CW-1:0]   i_buy_cnt,
    input  logic [CW-1:0]   i_sell_cnt,
    output logic            o_buy_ins,
    output logic            o_sell_ins,
    output logic [IW-1:0]   o_ins_pos,
    output t_entry          o_ins_data,
    output logic            o_buy_pop,
    output logic            o_sell_pop,
    output logic            o_buy_wr,
    output logic            o_sell_wr,
    output logic [QtyW-1:0] o_buy_qty,
    output logic [QtyW-1:0] o_sell_qty
);
    t_state r_state, n_state;
    t_req   r_req;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0] r_trades, n_trades;
    t_rsp r_rsp, n_rsp;
    logic [QtyW-1:0] r_bq, r_sq, n_bq, n_sq;

    logic [CW-1:0] cnt;
    t_entry cur, ins_e;
    logic [QtyW-1:0] t;
    logic is_buy_book;

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_DONE);
    assign o_rsp.payload = r_rsp;

    assign is_buy_book = (r_req.kind == K_PEEK_BUY) ||
                         (r_req.kind == K_ADD && r_req.is_buy);
    assign cnt   = is_buy_book ? i_buy_cnt : i_sell_cnt;
    assign cur   = is_buy_book ? i_buy_rd : i_sell_rd;
    assign ins_e = '{price: r_req.price, qty: r_req.quantity, id: r_req.order_id};

    // Address the books: scan position, peek rank or head
    always_comb begin
        o_buy_idx  = '0;
        o_sell_idx = '0;
        if (r_state == S_SCAN) begin
            o_buy_idx  = r_pos[IW-1:0];
            o_sell_idx = r_pos[IW-1:0];
        end else if (r_state == S_PEEK) begin
            o_buy_idx  = IW'(r_req.rank);
            o_sell_idx = IW'(r_req.rank);
        end
    end

    assign t = (i_buy_rd.qty < i_sell_rd.qty) ? i_buy_rd.qty : i_sell_rd.qty;

    // Next state and book controls
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_trades   = r_trades;
        n_rsp      = r_rsp;
        n_bq       = r_bq;
        n_sq       = r_sq;
        o_buy_ins  = 1'b0;
        o_sell_ins = 1'b0;
        o_ins_pos  = r_pos[IW-1:0];
        o_ins_data = ins_e;
        o_buy_pop  = 1'b0;
        o_sell_pop = 1'b0;
        o_buy_wr   = 1'b0;
        o_sell_wr  = 1'b0;
        o_buy_qty  = r_bq;
        o_sell_qty = r_sq;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_pos = '0;
                    n_rsp = '0;
                    unique case (t_kind'(i_req.payload.kind))
                        K_ADD:   n_state = S_SCAN;
                        K_MATCH: n_state = S_MCHK;
                        K_PEEK_BUY, K_PEEK_SELL: n_state = S_PEEK;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // Walk one entry a cycle until the order ranks ahead or none remain
            S_SCAN: begin
                if (cnt >= CW'(DEPTH)) begin
                    n_rsp.status = ST_FULL;
                    n_state = S_DONE;
                end else if (r_pos < cnt && !ranks_ahead(ins_e, cur, r_req.is_buy)) begin
                    n_pos = r_pos + CW'(1);
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_buy_ins  = r_req.is_buy;
                o_sell_ins = !r_req.is_buy;
                n_state    = S_DONE;
            end
            // If the heads cross, trade: compute remainders, write heads
            S_MCHK: begin
                if (i_buy_cnt != '0 && i_sell_cnt != '0 &&
                    i_buy_rd.price >= i_sell_rd.price) begin
                    n_trades  = r_trades + 32'd1;
                    n_bq      = i_buy_rd.qty - t;
                    n_sq      = i_sell_rd.qty - t;
                    o_buy_wr  = 1'b1;
                    o_sell_wr = 1'b1;
                    o_buy_qty = n_bq;
                    o_sell_qty = n_sq;
                    n_state   = S_MPOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            // Drop exhausted heads
            S_MPOP: begin
                o_buy_pop  = (r_bq == '0);
                o_sell_pop = (r_sq == '0);
                n_state    = S_MCHK;
            end
            S_PEEK: begin
                if (int'(r_req.rank) < int'(cnt)) begin
                    n_rsp.row_price    = cur.price;
                    n_rsp.row_quantity = cur.qty;
                    n_rsp.row_id       = cur.id;
                end else begin
                    n_rsp.status = ST_EMPTY;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state != S_DONE) n_rsp.trade_total = n_trades;
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_trades <= '0;
        end else begin
            r_state  <= n_state;
            r_trades <= n_trades;
        end
    end

    // Capture request and working data
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) r_req <= i_req.payload;
        r_pos <= n_pos;
        r_rsp <= n_rsp;
        r_bq  <= n_bq;
        r_sq  <= n_sq;
    end

`ifndef SYNTHESIS
    a_one_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_buy_ins && o_sell_ins)) else $error("double insert");
    a_trade_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MPOP |-> r_trades == $past(r_trades) + 32'd1)
        else $error("trade count slip");
    a_hold_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(r_rsp))
        else $error("response dropped");
`endif
endmodule

>>> hdl/price_time_order_matcher_unit.sv
// Price-time order matcher: limit order book with two sorted books.
// Request channel i_req carries kind, is_buy, price, quantity, order_id, rank.
// Response channel o_rsp carries status, row fields and trade_total.
// Exactly one response transaction per request transaction.
// One request at a time: i_req.ready is high only while idle.
// Add: the rank compare walks the resting entries in S_SCAN, then
// S_SHIFT inserts the order and S_DONE presents the response; a full book
// skips the shift and answers ST_FULL. Match: each trade round is a compare
// (S_MCHK) then a pop (S_MPOP), with fewer than 2*DEPTH rounds, then a final
// compare and the response. Peek: S_PEEK reads the entry at the given rank,
// then S_DONE responds. The unit returns to idle after each response
// transaction.
// The response stays in its register until o_rsp.ready; no new request is
// taken meanwhile.
// Reset (i_rst_n low, synchronous) empties both books and clears the trade
// count; book entries need no clearing pass, only the fill counts reset.
// Depends on ptom_pkg, ptom_if, ptom_book, ptom_ctrl.
module price_time_order_matcher_unit import ptom_pkg::*; #(
    parameter int unsigned BOOK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptom_req_if.sink   i_req,
    ptom_rsp_if.source o_rsp
);
    localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
    localparam int unsigned IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

    logic [IW-1:0] buy_idx, sell_idx, ins_pos;
    t_entry buy_rd, sell_rd, ins_data;
    logic [CW-1:0] buy_cnt, sell_cnt;
    logic buy_ins, sell_ins, buy_pop, sell_pop, buy_wr, sell_wr;
    logic [QtyW-1:0] buy_qty, sell_qty;

    ptom_ctrl #(.DEPTH(BOOK_DEPTH), .CW(CW), .IW(IW)) u_ctrl (
        .i_clk, .i_rst_n, .i_req, .o_rsp,
        .o_buy_idx(buy_idx), .o_sell_idx(sell_idx),
        .i_buy_rd(buy_rd), .i_sell_rd(sell_rd),
        .i_buy_cnt(buy_cnt), .i_sell_cnt(sell_cnt),
        .o_buy_ins(buy_ins), .o_sell_ins(sell_ins),
        .o_ins_pos(ins_pos), .o_ins_data(ins_data),
        .o_buy_pop(buy_pop), .o_sell_pop(sell_pop),
        .o_buy_wr(buy_wr), .o_sell_wr(sell_wr),
        .o_buy_qty(buy_qty), .o_sell_qty(sell_qty)
    );

    ptom_book #(.DEPTH(BOOK_DEPTH), .CW(CW), .IW(IW)) u_buy (
        .i_clk, .i_rst_n, .i_rd_idx(buy_idx), .o_rd_data(buy_rd),
        .i_ins(buy_ins), .i_ins_pos(ins_pos), .i_ins_data(ins_data),
        .i_pop(buy_pop), .i_wr_head(buy_wr), .i_head_qty(buy_qty),
        .o_count(buy_cnt)
    );

    ptom_book #(.DEPTH(BOOK_DEPTH), .CW(CW), .IW(IW)) u_sell (
        .i_clk, .i_rst_n, .i_rd_idx(sell_idx), .o_rd_data(sell_rd),
        .i_ins(sell_ins), .i_ins_pos(ins_pos), .i_ins_data(ins_data),
        .i_pop(sell_pop), .i_wr_head(sell_wr), .i_head_qty(sell_qty),
        .o_count(sell_cnt)
    );
endmodule
